// ----- hw/rtl/bivariate_gauss_covariance_macros.svh -----
// Assertion macros shared by the bivariate Gaussian covariance block.
`ifndef BIVARIATE_GAUSS_COVARIANCE_MACROS_SVH
`define BIVARIATE_GAUSS_COVARIANCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bgc_pkg.sv -----
// Shared types and constants of the bivariate Gaussian covariance block.
package bgc_pkg;

  localparam int LAG_W = 16;
  localparam int NUM_LAGS = 4;
  localparam int RES_W = 16;
  localparam int DW = 17;
  localparam int TW = 36;
  localparam int MW = 31;
  localparam int KW = 5;
  localparam int HW = 31;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int TERMS = 12;
  localparam int KR_STEPS = 5;
  localparam int EXP_LAT = KR_STEPS + 3 * TERMS + 1;
  localparam int DIV_STEPS = TW;

  typedef enum logic [1:0] {
    REG_DIM = 2'd0,
    REG_NU  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic            busy;
    logic [DW-1:0]   denom;
    logic [HW-1:0]   root;
  } cfg_state_t;

endpackage

// ----- hw/rtl/bivariate_gauss_covariance.sv -----
// Top level of the bivariate Gaussian covariance evaluator.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  lag_0..lag_3
//   m_axis    out        m_axis_tvalid/m_axis_tready  auto_cov, cross_cov
//   cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One item is taken per cycle, except while the pipeline halts or a recompute runs.
// The pipeline runs through the 36-stage divider and the two 42-stage exp pipes.
// After reset and after each register write, the root factor is recomputed
// by a bit-serial divide and square root; no item is taken then.
// A two-entry output buffer lets the pipeline keep moving while a result
// waits; the pipeline halts only while that buffer is full and a result
// waits to enter it.
`include "bivariate_gauss_covariance_macros.svh"

module bivariate_gauss_covariance #(
  parameter int MAX_DIM = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // lag_0, lag_1, lag_2, lag_3
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // auto_cov, cross_cov
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEW = $clog2(MAX_DIM + 1);
  localparam int QW  = 31 + $clog2(MAX_DIM);
  localparam int SW  = 17 + $clog2(MAX_DIM);
  localparam int NW  = QW + bgc_pkg::DW;
  localparam int SQW = 2 * bgc_pkg::LAG_W - 1;
  localparam int LAT = 4 + bgc_pkg::DIV_STEPS + bgc_pkg::EXP_LAT + 2;
  localparam int SIDE_W = 2 + bgc_pkg::TW;

  logic [DEW-1:0]       deff;
  bgc_pkg::cfg_state_t  cst;

  bgc_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .deff(deff), .st(cst)
  );

  logic       en;
  logic [1:0] cnt;
  logic [LAT-1:0] vld;
  logic       push;
  logic       pop;

  assign en            = !(cnt == 2'd2 && vld[LAT-1]);
  assign s_axis_tready = en && !cst.busy;
  assign push          = en && vld[LAT-1];
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  logic signed [bgc_pkg::LAG_W-1:0] lag [bgc_pkg::NUM_LAGS];
  for (genvar j = 0; j < bgc_pkg::NUM_LAGS; j++) begin : g_lag
    assign lag[j] = s_axis_tdata[bgc_pkg::LAG_W*j +: bgc_pkg::LAG_W];
  end

  logic        [SQW-1:0]           ln_sq [MAX_DIM];
  logic signed [bgc_pkg::LAG_W-1:0] ln_x [MAX_DIM];

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_lane
    logic signed [bgc_pkg::LAG_W-1:0] lin;
    if (i < bgc_pkg::NUM_LAGS) begin : g_src
      assign lin = lag[i];
    end else begin : g_nosrc
      assign lin = '0;
    end
    bgc_lane u_lane (
      .clk(clk), .en(en), .use_it(DEW'(i) < deff), .lag(lin),
      .sq(ln_sq[i]), .x(ln_x[i])
    );
  end

  logic        [QW-1:0] q_sum;
  logic signed [SW-1:0] s_sum;

  always_comb begin
    q_sum = '0;
    s_sum = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      q_sum = q_sum + QW'(ln_sq[i]);
      s_sum = s_sum + SW'(ln_x[i]);
    end
  end

  logic        [QW-1:0] q2;
  logic signed [SW-1:0] s2r;

  always_ff @(posedge clk) begin
    if (en) begin
      q2  <= q_sum;
      s2r <= s_sum;
    end
  end

  logic [SW-1:0]          s_abs;
  logic [2*SW-1:0]        s3_sq;
  logic [NW-1:0]          s3_qd;
  logic                   s3_dz;
  logic [bgc_pkg::TW-1:0] s3_td;

  assign s_abs = (s2r < 0) ? SW'(-s2r) : SW'(s2r);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sq <= s_abs * s_abs;
      s3_qd <= q2 * cst.denom;
      s3_dz <= (q2 >= QW'(12 << 24));
      s3_td <= {q2[27:0], 8'h00};
    end
  end

  logic [NW-1:0]          sub;
  logic [NW-1:0]          nval;
  logic [NW-1:0]          lim;
  logic                   s4_oz;
  logic                   s4_dz;
  logic [bgc_pkg::TW-1:0] s4_td;
  logic [bgc_pkg::DW-1:0] s4_rem;
  logic [bgc_pkg::TW-1:0] s4_low;

  assign sub  = NW'(s3_sq) << 8;
  assign nval = (s3_qd > sub) ? s3_qd - sub : '0;
  assign lim  = (NW'(cst.denom) * NW'(12)) << 24;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_oz  <= (nval >= lim);
      s4_rem <= (nval >= lim) ? '0 : nval[28 + bgc_pkg::DW - 1:28];
      s4_low <= {nval[27:0], 8'h00};
      s4_dz  <= s3_dz;
      s4_td  <= s3_td;
    end
  end

  logic [bgc_pkg::TW-1:0] quo;
  logic [SIDE_W-1:0]      side;

  bgc_div #(.SIDE_W(SIDE_W)) u_div (
    .clk(clk), .en(en), .rem0(s4_rem), .low(s4_low), .den(cst.denom),
    .side_in({s4_dz, s4_oz, s4_td}), .quo(quo), .side_out(side)
  );

  logic [bgc_pkg::MW-1:0] m_d;
  logic [bgc_pkg::KW-1:0] k_d;
  logic [bgc_pkg::MW-1:0] m_o;
  logic [bgc_pkg::KW-1:0] k_o;

  bgc_exp u_exp_auto (
    .clk(clk), .en(en), .t(side[bgc_pkg::TW-1:0]), .zero(side[SIDE_W-1]),
    .m(m_d), .k(k_d)
  );

  bgc_exp u_exp_cross (
    .clk(clk), .en(en), .t(quo), .zero(side[SIDE_W-2]),
    .m(m_o), .k(k_o)
  );

  logic [31:0]                  ad_sum;
  logic [31:0]                  ad_shr;
  logic [bgc_pkg::RES_W-1:0]    p_auto;
  logic [bgc_pkg::HW+bgc_pkg::MW-1:0] p_prod;
  logic [bgc_pkg::KW-1:0]       p_k;

  assign ad_sum = {1'b0, m_d} + (32'd1 << (6'(k_d) + 6'd14));
  assign ad_shr = ad_sum >> (6'(k_d) + 6'd15);

  always_ff @(posedge clk) begin
    if (en) begin
      p_auto <= ad_shr[bgc_pkg::RES_W-1:0];
      p_prod <= cst.root * m_o;
      p_k    <= k_o;
    end
  end

  logic [63:0]               cr_sum;
  logic [63:0]               cr_shr;
  logic [2*bgc_pkg::RES_W-1:0] f_data;

  assign cr_sum = 64'(p_prod) + (64'd1 << (7'(p_k) + 7'd44));
  assign cr_shr = cr_sum >> (7'(p_k) + 7'd45);

  always_ff @(posedge clk) begin
    if (en) begin
      f_data <= {cr_shr[bgc_pkg::RES_W-1:0], p_auto};
    end
  end

  logic [2*bgc_pkg::RES_W-1:0] sk0;
  logic [2*bgc_pkg::RES_W-1:0] sk1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case (cnt)
        2'd0: begin
          if (push) begin
            sk0 <= f_data;
            cnt <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            sk0 <= f_data;
          end else if (push) begin
            sk1 <= f_data;
            cnt <= 2'd2;
          end else if (pop) begin
            cnt <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            sk0 <= sk1;
            if (push) begin
              sk1 <= f_data;
            end else begin
              cnt <= 2'd1;
            end
          end
        end
        default: cnt <= 2'd0;
      endcase
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = sk0;

  `BGC_ASSERT_NOW(a_no_item_while_busy, cst.busy, !s_axis_tready, "item during recompute")
  `BGC_ASSERT_NEXT(a_cfg_write_busy, cfg_valid && cfg_ready, cst.busy, "no recompute")
  `BGC_ASSERT_NOW(a_buffer_bounded, cnt == 2'd2 && !m_axis_tready, !push, "buffer overflow")

endmodule

// ----- hw/rtl/bgc_lane.sv -----
// One component lane: squares a lag component, or zero when the lane is unused, and passes it on.
module bgc_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic                               use_it,
  input  logic signed [bgc_pkg::LAG_W-1:0]   lag,
  output logic        [2*bgc_pkg::LAG_W-2:0] sq,
  output logic signed [bgc_pkg::LAG_W-1:0]   x
);

  logic signed [bgc_pkg::LAG_W-1:0]   xv;
  logic signed [2*bgc_pkg::LAG_W-1:0] prod;

  assign xv = use_it ? lag : '0;
  assign prod = xv * xv;

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= prod[2*bgc_pkg::LAG_W-2:0];
      x  <= xv;
    end
  end

endmodule

// ----- hw/rtl/bgc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side bus.
module bgc_div #(
  parameter int SIDE_W = 38
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [bgc_pkg::DW-1:0]  rem0,
  input  logic [bgc_pkg::TW-1:0]  low,
  input  logic [bgc_pkg::DW-1:0]  den,
  input  logic [SIDE_W-1:0]       side_in,
  output logic [bgc_pkg::TW-1:0]  quo,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int N = bgc_pkg::DIV_STEPS;

  logic [bgc_pkg::DW-1:0] rem_s  [N+1];
  logic [bgc_pkg::TW-1:0] low_s  [N+1];
  logic [bgc_pkg::TW-1:0] quo_s  [N+1];
  logic [SIDE_W-1:0]      side_s [N+1];

  assign rem_s[0]  = rem0;
  assign low_s[0]  = low;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_in;

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [bgc_pkg::DW:0] cur;
    logic [bgc_pkg::DW:0] diff;
    logic                 ge;
    assign cur  = {rem_s[j], low_s[j][bgc_pkg::TW-1]};
    assign diff = cur - {1'b0, den};
    assign ge   = (cur >= {1'b0, den});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1]  <= ge ? diff[bgc_pkg::DW-1:0] : cur[bgc_pkg::DW-1:0];
        low_s[j+1]  <= {low_s[j][bgc_pkg::TW-2:0], 1'b0};
        quo_s[j+1]  <= {quo_s[j][bgc_pkg::TW-2:0], ge};
        side_s[j+1] <= side_s[j];
      end
    end
  end

  assign quo      = quo_s[N];
  assign side_out = side_s[N];

endmodule

// ----- hw/rtl/bgc_exp.sv -----
// Pipelined exp(-t): range reduction by ln2, then a truncated Taylor series.
module bgc_exp (
  input  logic                    clk,
  input  logic                    en,
  input  logic [bgc_pkg::TW-1:0]  t,
  input  logic                    zero,
  output logic [bgc_pkg::MW-1:0]  m,
  output logic [bgc_pkg::KW-1:0]  k
);

  localparam int KS = bgc_pkg::KR_STEPS;
  localparam int NT = bgc_pkg::TERMS;

  logic [bgc_pkg::TW-1:0] kr_t [KS+1];
  logic [bgc_pkg::KW-1:0] kr_k [KS+1];
  logic                   kr_z [KS+1];

  assign kr_t[0] = t;
  assign kr_k[0] = '0;
  assign kr_z[0] = zero;

  for (genvar j = 0; j < KS; j++) begin : g_kr
    localparam logic [bgc_pkg::TW-1:0] STEP =
      bgc_pkg::TW'({4'b0, bgc_pkg::LN2_Q32} << (KS - 1 - j));
    logic ge;
    assign ge = (kr_t[j] >= STEP);
    always_ff @(posedge clk) begin
      if (en) begin
        kr_t[j+1] <= ge ? kr_t[j] - STEP : kr_t[j];
        kr_k[j+1] <= {kr_k[j][bgc_pkg::KW-2:0], ge};
        kr_z[j+1] <= kr_z[j];
      end
    end
  end

  logic [32:0]            c_term [NT+1];
  logic [33:0]            c_acc  [NT+1];
  logic [31:0]            c_r    [NT+1];
  logic [bgc_pkg::KW-1:0] c_k    [NT+1];
  logic                   c_z    [NT+1];

  assign c_term[0] = 33'h1_0000_0000;
  assign c_acc[0]  = 34'h1_0000_0000;
  assign c_r[0]    = kr_t[KS][31:0];
  assign c_k[0]    = kr_k[KS];
  assign c_z[0]    = kr_z[KS];

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int DV = j + 1;
    localparam logic [35:0] RCP = 36'(((64'd1 << 36) - 64'd1) / DV);
    logic [64:0]            pa;
    logic [31:0]            a_x;
    logic [33:0]            a_acc;
    logic [31:0]            a_r;
    logic [bgc_pkg::KW-1:0] a_k;
    logic                   a_z;
    logic [67:0]            b_pq;
    logic [31:0]            b_x;
    logic [33:0]            b_acc;
    logic [31:0]            b_r;
    logic [bgc_pkg::KW-1:0] b_k;
    logic                   b_z;
    logic [31:0]            qq;
    logic [35:0]            rm;
    logic [31:0]            qc;

    assign pa = c_term[j] * c_r[j];
    always_ff @(posedge clk) begin
      if (en) begin
        a_x   <= pa[63:32];
        a_acc <= c_acc[j];
        a_r   <= c_r[j];
        a_k   <= c_k[j];
        a_z   <= c_z[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        b_pq  <= a_x * RCP;
        b_x   <= a_x;
        b_acc <= a_acc;
        b_r   <= a_r;
        b_k   <= a_k;
        b_z   <= a_z;
      end
    end

    assign qq = b_pq[67:36];
    assign rm = {4'b0, b_x} - 36'(qq) * 36'(DV);
    assign qc = (rm >= 36'(DV)) ? qq + 32'd1 : qq;

    always_ff @(posedge clk) begin
      if (en) begin
        c_term[j+1] <= {1'b0, qc};
        c_acc[j+1]  <= (DV % 2 == 1) ? b_acc - {2'b0, qc} : b_acc + {2'b0, qc};
        c_r[j+1]    <= b_r;
        c_k[j+1]    <= b_k;
        c_z[j+1]    <= b_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m <= c_z[NT] ? '0 : c_acc[NT][32:2];
      k <= c_z[NT] ? '0 : c_k[NT];
    end
  end

endmodule

// ----- hw/rtl/bgc_cfg.sv -----
// Configuration registers and the derived denominator and root factor.
module bgc_cfg #(
  parameter int MAX_DIM = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data,
  output logic [$clog2(MAX_DIM+1)-1:0]       deff,
  output bgc_pkg::cfg_state_t                st
);

  localparam int DEW = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_SQRT, ST_IDLE} state_t;

  state_t                 state;
  logic [2:0]             dim_reg;
  logic [15:0]            nu_reg;
  logic [bgc_pkg::DW-1:0] den;
  logic [45:0]            num;
  logic [bgc_pkg::DW-1:0] rem;
  logic [29:0]            quo;
  logic [5:0]             cnt;
  logic [63:0]            sv;
  logic [63:0]            sres;
  logic [63:0]            sbit;
  logic [bgc_pkg::HW-1:0] root;

  logic [bgc_pkg::DW:0]   cur;
  logic                   ge;
  logic [bgc_pkg::DW:0]   diff;
  logic [29:0]            quo_next;
  logic [63:0]            trial;
  logic                   sge;
  logic [63:0]            sres_next;

  always_comb begin
    if (dim_reg == 3'd0) begin
      deff = DEW'(1);
    end else if (int'(dim_reg) > MAX_DIM) begin
      deff = DEW'(MAX_DIM);
    end else begin
      deff = DEW'(dim_reg);
    end
  end

  assign cur       = {rem, num[45]};
  assign ge        = (cur >= {1'b0, den});
  assign diff      = cur - {1'b0, den};
  assign quo_next  = {quo[28:0], ge};
  assign trial     = sres + sbit;
  assign sge       = (sv >= trial);
  assign sres_next = sge ? (sres >> 1) + sbit : sres >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      dim_reg <= 3'd4;
      nu_reg  <= 16'd256;
    end else begin
      unique case (state)
        ST_LOAD: begin
          den   <= bgc_pkg::DW'({deff, 8'h00}) + bgc_pkg::DW'(nu_reg);
          num   <= {nu_reg, 30'b0};
          rem   <= '0;
          quo   <= '0;
          cnt   <= 6'd45;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? diff[bgc_pkg::DW-1:0] : cur[bgc_pkg::DW-1:0];
          quo <= quo_next;
          num <= {num[44:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            sv    <= {4'b0, quo_next, 30'b0};
            sres  <= '0;
            sbit  <= 64'd1 << 62;
            cnt   <= 6'd31;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sge) begin
            sv <= sv - trial;
          end
          sres <= sres_next;
          sbit <= sbit >> 2;
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            root  <= sres_next[bgc_pkg::HW-1:0];
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              bgc_pkg::REG_DIM: dim_reg <= cfg_data[2:0];
              bgc_pkg::REG_NU:  nu_reg  <= cfg_data;
              default: ;
            endcase
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign cfg_ready = (state == ST_IDLE);
  assign st.busy   = (state != ST_IDLE);
  assign st.denom  = den;
  assign st.root   = root;

endmodule
